/* rtl/pm25_air_quality_index_assert.svh */
// Assertion macros for the PM2.5 air quality index block.
// Included by the top level; no other dependencies.
`ifndef PM25_AIR_QUALITY_INDEX_ASSERT_SVH
`define PM25_AIR_QUALITY_INDEX_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define PM25_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define PM25_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/pm25aqi_pkg.sv */
// Package for the PM2.5 air quality index block: widths, band codes,
// band constant tables and the pipeline enable struct. No dependencies.
package pm25aqi_pkg;

  localparam int XW   = 16;  // concentration in tenths
  localparam int AW   = 9;   // index
  localparam int CW   = 3;   // category
  localparam int BW   = 3;   // band code
  localparam int OFW  = 11;  // offset inside a band
  localparam int DIW  = 7;   // index span of a band
  localparam int SPW  = 11;  // concentration span of a band
  localparam int NW   = 19;  // rounding numerator
  localparam int MW   = 17;  // reciprocal
  localparam int SH   = 24;  // reciprocal scale
  localparam int PW   = NW + MW;
  localparam int QW   = 7;   // quotient
  localparam int DW   = 12;  // divisor
  localparam int QDW  = QW + DW;
  localparam int NSTG = 5;

  localparam logic [AW-1:0] TOP_INDEX    = AW'(500);
  localparam logic [CW-1:0] TOP_CATEGORY = CW'(5);

  localparam logic [BW-1:0] BAND_0    = 3'd0;
  localparam logic [BW-1:0] BAND_1    = 3'd1;
  localparam logic [BW-1:0] BAND_2    = 3'd2;
  localparam logic [BW-1:0] BAND_3    = 3'd3;
  localparam logic [BW-1:0] BAND_4    = 3'd4;
  localparam logic [BW-1:0] BAND_5    = 3'd5;
  localparam logic [BW-1:0] BAND_6    = 3'd6;
  localparam logic [BW-1:0] BAND_OVER = 3'd7;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pm25aqi_en_t;

  function automatic logic [BW-1:0] band_of(input logic [XW-1:0] x);
    logic [BW-1:0] b;
    if (x <= XW'(120)) begin
      b = BAND_0;
    end else if (x <= XW'(354)) begin
      b = BAND_1;
    end else if (x <= XW'(554)) begin
      b = BAND_2;
    end else if (x <= XW'(1504)) begin
      b = BAND_3;
    end else if (x <= XW'(2504)) begin
      b = BAND_4;
    end else if (x <= XW'(3504)) begin
      b = BAND_5;
    end else if (x <= XW'(5004)) begin
      b = BAND_6;
    end else begin
      b = BAND_OVER;
    end
    return b;
  endfunction

  function automatic logic [XW-1:0] band_clo(input logic [BW-1:0] b);
    logic [XW-1:0] v;
    unique case (b)
      BAND_0:  v = XW'(0);
      BAND_1:  v = XW'(121);
      BAND_2:  v = XW'(355);
      BAND_3:  v = XW'(555);
      BAND_4:  v = XW'(1505);
      BAND_5:  v = XW'(2505);
      BAND_6:  v = XW'(3505);
      default: v = XW'(0);
    endcase
    return v;
  endfunction

  function automatic logic [SPW-1:0] band_span(input logic [BW-1:0] b);
    logic [SPW-1:0] v;
    unique case (b)
      BAND_0:  v = SPW'(120);
      BAND_1:  v = SPW'(233);
      BAND_2:  v = SPW'(199);
      BAND_3:  v = SPW'(949);
      BAND_4:  v = SPW'(999);
      BAND_5:  v = SPW'(999);
      BAND_6:  v = SPW'(1499);
      default: v = SPW'(0);
    endcase
    return v;
  endfunction

  function automatic logic [DIW-1:0] band_dil(input logic [BW-1:0] b);
    logic [DIW-1:0] v;
    unique case (b)
      BAND_0:  v = DIW'(50);
      BAND_1:  v = DIW'(49);
      BAND_2:  v = DIW'(49);
      BAND_3:  v = DIW'(49);
      BAND_4:  v = DIW'(99);
      BAND_5:  v = DIW'(99);
      BAND_6:  v = DIW'(99);
      default: v = DIW'(0);
    endcase
    return v;
  endfunction

  function automatic logic [AW-1:0] band_ilo(input logic [BW-1:0] b);
    logic [AW-1:0] v;
    unique case (b)
      BAND_0:  v = AW'(0);
      BAND_1:  v = AW'(51);
      BAND_2:  v = AW'(101);
      BAND_3:  v = AW'(151);
      BAND_4:  v = AW'(201);
      BAND_5:  v = AW'(301);
      BAND_6:  v = AW'(401);
      default: v = TOP_INDEX;
    endcase
    return v;
  endfunction

  function automatic logic [CW-1:0] band_cat(input logic [BW-1:0] b);
    logic [CW-1:0] v;
    unique case (b)
      BAND_0:  v = CW'(0);
      BAND_1:  v = CW'(1);
      BAND_2:  v = CW'(2);
      BAND_3:  v = CW'(3);
      BAND_4:  v = CW'(4);
      BAND_5:  v = CW'(5);
      BAND_6:  v = CW'(5);
      default: v = TOP_CATEGORY;
    endcase
    return v;
  endfunction

  // divisor: twice the concentration span
  function automatic logic [DW-1:0] band_div(input logic [BW-1:0] b);
    logic [DW-1:0] v;
    unique case (b)
      BAND_0:  v = DW'(240);
      BAND_1:  v = DW'(466);
      BAND_2:  v = DW'(398);
      BAND_3:  v = DW'(1898);
      BAND_4:  v = DW'(1998);
      BAND_5:  v = DW'(1998);
      BAND_6:  v = DW'(2998);
      default: v = DW'(1);
    endcase
    return v;
  endfunction

  // floor(2^SH / divisor)
  function automatic logic [MW-1:0] band_recip(input logic [BW-1:0] b);
    logic [MW-1:0] v;
    unique case (b)
      BAND_0:  v = MW'(69905);
      BAND_1:  v = MW'(36002);
      BAND_2:  v = MW'(42153);
      BAND_3:  v = MW'(8839);
      BAND_4:  v = MW'(8397);
      BAND_5:  v = MW'(8397);
      BAND_6:  v = MW'(5596);
      default: v = MW'(0);
    endcase
    return v;
  endfunction

endpackage

/* rtl/pm25_air_quality_index.sv */
// Top level of the PM2.5 air quality index block: stage valid bits and
// stall control. Depends on pm25aqi_pkg, pm25aqi_band, pm25aqi_div and the assertion header.
//
// Usage:
//   Input channel in_valid / in_stall / in_pm25_tenths carries one
//   concentration in tenths of ug/m3 per transaction. Output channel
//   out_valid / out_stall / out_aqi_value / out_category returns one
//   index (0..500) and health category (0..5) per input, in order.
//   A transaction completes at a rising edge with valid high and stall low.
//   Throughput is one transaction per cycle while out_stall is low; the
//   pipeline has five register stages (band select, numerator multiply,
//   reciprocal multiply, divisor multiply, correction).
//   Concentrations above 500.4 give index 500, category 5.
//   Reset (rst_n low, synchronous) clears all stage valid bits; the stage
//   data registers are not reset. When out_stall is high the last stage holds its
//   transaction; earlier stages keep filling bubbles, and in_stall rises
//   only once every stage holds a transaction.
module pm25_air_quality_index (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pm25aqi_pkg::XW-1:0]  in_pm25_tenths,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pm25aqi_pkg::AW-1:0]  out_aqi_value,
  output logic [pm25aqi_pkg::CW-1:0]  out_category
);

  `include "pm25_air_quality_index_assert.svh"

  logic [pm25aqi_pkg::NSTG-1:0] valid_r;
  logic [pm25aqi_pkg::NSTG-1:0] valid_nxt;
  logic [pm25aqi_pkg::NSTG-1:0] rdy;
  pm25aqi_pkg::pm25aqi_en_t     en;
  logic [pm25aqi_pkg::BW-1:0]   band2;
  logic [pm25aqi_pkg::NW-1:0]   num2;

  always_comb begin
    rdy[pm25aqi_pkg::NSTG-1] = !valid_r[pm25aqi_pkg::NSTG-1] || !out_stall;
    for (int i = pm25aqi_pkg::NSTG-2; i >= 0; i--) begin
      rdy[i] = !valid_r[i] || rdy[i+1];
    end
    valid_nxt[0] = rdy[0] ? in_valid : valid_r[0];
    for (int i = 1; i < pm25aqi_pkg::NSTG; i++) begin
      valid_nxt[i] = rdy[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  assign en = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3], s5: rdy[4]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  pm25aqi_band u_band (
    .clk         (clk),
    .en          (en),
    .pm25_tenths (in_pm25_tenths),
    .band2_r     (band2),
    .num2_r      (num2)
  );

  pm25aqi_div u_div (
    .clk    (clk),
    .en     (en),
    .band2  (band2),
    .num2   (num2),
    .aqi5_r (out_aqi_value),
    .cat5_r (out_category)
  );

  assign in_stall  = !rdy[0];
  assign out_valid = valid_r[pm25aqi_pkg::NSTG-1];

  `PM25_ASSERT_IMP(a_index_range, out_valid, out_aqi_value <= pm25aqi_pkg::TOP_INDEX)
  `PM25_ASSERT_IMP(a_good_band, out_valid,
                   (out_category == 3'd0) == (out_aqi_value <= 9'd50))
  `PM25_ASSERT_IMP(a_stall_full, in_stall, valid_r == {pm25aqi_pkg::NSTG{1'b1}})
  `PM25_ASSERT_NXT(a_drain, out_valid && !out_stall && !valid_r[pm25aqi_pkg::NSTG-2],
                   !out_valid)

endmodule

/* rtl/pm25aqi_band.sv */
// Band select and rounding numerator, pipeline stages one and two.
// Depends on pm25aqi_pkg.
module pm25aqi_band (
  input  logic                         clk,
  input  pm25aqi_pkg::pm25aqi_en_t     en,
  input  logic [pm25aqi_pkg::XW-1:0]   pm25_tenths,
  output logic [pm25aqi_pkg::BW-1:0]   band2_r,
  output logic [pm25aqi_pkg::NW-1:0]   num2_r
);

  logic [pm25aqi_pkg::BW-1:0]  band1_r;
  logic [pm25aqi_pkg::OFW-1:0] xoff1_r;
  logic [pm25aqi_pkg::BW-1:0]  band1_nxt;
  logic [pm25aqi_pkg::XW-1:0]  diff;
  logic [pm25aqi_pkg::OFW-1:0] xoff1_nxt;
  logic [pm25aqi_pkg::DIW+pm25aqi_pkg::OFW-1:0] prod;
  logic [pm25aqi_pkg::NW-1:0]  num2_nxt;

  always_comb begin
    band1_nxt = pm25aqi_pkg::band_of(pm25_tenths);
    diff      = pm25_tenths - pm25aqi_pkg::band_clo(band1_nxt);
    xoff1_nxt = (band1_nxt == pm25aqi_pkg::BAND_OVER) ? '0 : diff[pm25aqi_pkg::OFW-1:0];
  end

  always_comb begin
    prod     = (pm25aqi_pkg::DIW+pm25aqi_pkg::OFW)'(pm25aqi_pkg::band_dil(band1_r)) *
               (pm25aqi_pkg::DIW+pm25aqi_pkg::OFW)'(xoff1_r);
    num2_nxt = pm25aqi_pkg::NW'({prod, 1'b0}) +
               pm25aqi_pkg::NW'(pm25aqi_pkg::band_span(band1_r));
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      band1_r <= band1_nxt;
      xoff1_r <= xoff1_nxt;
    end
    if (en.s2) begin
      band2_r <= band1_r;
      num2_r  <= num2_nxt;
    end
  end

endmodule

/* rtl/pm25aqi_div.sv */
// Division by the band divisor through a reciprocal multiply with one
// correction step, and the final index and category; stages three to five.
// Depends on pm25aqi_pkg.
module pm25aqi_div (
  input  logic                         clk,
  input  pm25aqi_pkg::pm25aqi_en_t     en,
  input  logic [pm25aqi_pkg::BW-1:0]   band2,
  input  logic [pm25aqi_pkg::NW-1:0]   num2,
  output logic [pm25aqi_pkg::AW-1:0]   aqi5_r,
  output logic [pm25aqi_pkg::CW-1:0]   cat5_r
);

  logic [pm25aqi_pkg::BW-1:0]  band3_r;
  logic [pm25aqi_pkg::NW-1:0]  num3_r;
  logic [pm25aqi_pkg::QW-1:0]  qe3_r;
  logic [pm25aqi_pkg::BW-1:0]  band4_r;
  logic [pm25aqi_pkg::NW-1:0]  num4_r;
  logic [pm25aqi_pkg::QW-1:0]  qe4_r;
  logic [pm25aqi_pkg::QDW-1:0] qd4_r;
  logic [pm25aqi_pkg::PW-1:0]  prod;
  logic [pm25aqi_pkg::QW-1:0]  qe3_nxt;
  logic [pm25aqi_pkg::QDW-1:0] qd4_nxt;
  logic [pm25aqi_pkg::NW-1:0]  rem;
  logic [pm25aqi_pkg::QW-1:0]  quot;
  logic [pm25aqi_pkg::AW-1:0]  aqi5_nxt;

  always_comb begin
    prod    = pm25aqi_pkg::PW'(num2) * pm25aqi_pkg::PW'(pm25aqi_pkg::band_recip(band2));
    qe3_nxt = prod[pm25aqi_pkg::SH +: pm25aqi_pkg::QW];
  end

  assign qd4_nxt = pm25aqi_pkg::QDW'(qe3_r) *
                   pm25aqi_pkg::QDW'(pm25aqi_pkg::band_div(band3_r));

  // the estimate is low by at most one
  always_comb begin
    rem  = num4_r - qd4_r;
    quot = qe4_r +
           pm25aqi_pkg::QW'(rem >= pm25aqi_pkg::NW'(pm25aqi_pkg::band_div(band4_r)));
    aqi5_nxt = (band4_r == pm25aqi_pkg::BAND_OVER) ? pm25aqi_pkg::TOP_INDEX :
               pm25aqi_pkg::band_ilo(band4_r) + pm25aqi_pkg::AW'(quot);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      band3_r <= band2;
      num3_r  <= num2;
      qe3_r   <= qe3_nxt;
    end
    if (en.s4) begin
      band4_r <= band3_r;
      num4_r  <= num3_r;
      qe4_r   <= qe3_r;
      qd4_r   <= qd4_nxt;
    end
    if (en.s5) begin
      aqi5_r <= aqi5_nxt;
      cat5_r <= pm25aqi_pkg::band_cat(band4_r);
    end
  end

endmodule
